FILE: src/assert_macros.svh
// Assertion macros for the Pareto front filter.
// No dependencies; the user must provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define PPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define PPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ppf_pkg.sv
// Shared types and constants for the partitioned Pareto front filter.
// No dependencies.
`default_nettype none
package ppf_pkg;

  localparam int MaxRows     = 64;
  localparam int MaxCriteria = 8;
  localparam int RowIdxW     = $clog2(MaxRows);
  localparam int RowCntW     = $clog2(MaxRows + 1);
  localparam int CritCntW    = 4;

  localparam logic [CritCntW-1:0] CritReset = CritCntW'(2);
  localparam logic [2:0]          RegCritAddr = 3'd0;

  typedef struct packed {
    logic [15:0]        partition_id;
    logic               row_excluded;
    logic signed [31:0] criterion_1;
    logic signed [31:0] criterion_2;
    logic signed [31:0] criterion_3;
    logic signed [31:0] criterion_4;
    logic signed [31:0] criterion_5;
    logic signed [31:0] criterion_6;
    logic signed [31:0] criterion_7;
    logic signed [31:0] criterion_8;
    logic               last_row;
  } row_in_t;

  typedef struct packed {
    logic [63:0]        keep_mask;
    logic [RowCntW-1:0] rows_loaded;
    logic               overflow;
  } result_t;

  typedef logic signed [31:0] crit_vec_t [MaxCriteria];

  typedef struct packed {
    logic [CritCntW-1:0] crit_cnt;
    logic                earlier;
  } cmp_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CAND_RD,
    ST_CAND_LD,
    ST_SWEEP,
    ST_DRAIN,
    ST_NEXT
  } state_t;

endpackage
`default_nettype wire

FILE: src/partitioned_pareto_front_filter.sv
// Rows load one per cycle while no result is waiting. After the last row, each
// stored row is compared in turn against every stored row; excluded rows skip
// the sweep. The single read port of the row memory feeds the comparator lanes.
// The result then waits in an output register; input stalls until it is taken.
// Reset (synchronous, active low) clears row count, overflow, output valid and
// sets crit_r to 2; row memory contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module partitioned_pareto_front_filter (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ppf_pkg::row_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ppf_pkg::result_t      out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  ppf_pkg::row_in_t mem [ppf_pkg::MaxRows];
  ppf_pkg::row_in_t rd_data_r;
  ppf_pkg::row_in_t cand_r;

  ppf_pkg::state_t state_r, state_nxt;
  logic [ppf_pkg::RowCntW-1:0]  cnt_r;
  logic                         ovf_r;
  logic [ppf_pkg::RowIdxW-1:0]  i_r, j_r, pj_r;
  logic                         pv_r;
  logic                         kept_r;
  logic [63:0]                  mask_r;
  logic [ppf_pkg::CritCntW-1:0] crit_r;
  logic                         out_valid_r;
  ppf_pkg::result_t             out_data_r;

  logic                         in_xfer;
  logic [ppf_pkg::RowIdxW-1:0]  rd_addr;
  logic                         issue;
  logic                         j_last, i_last;
  logic [ppf_pkg::CritCntW-1:0] crit_eff;
  ppf_pkg::cmp_ctl_t            ctl;
  ppf_pkg::crit_vec_t           dom_crit, cand_crit;
  logic                         dom;
  logic                         hit;
  logic                         cfg_wr;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ppf_pkg::RegCritAddr);
  assign prdata = (paddr == ppf_pkg::RegCritAddr) ? {28'd0, crit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_r <= ppf_pkg::CritReset;
    end else if (cfg_wr) begin
      crit_r <= pwdata[ppf_pkg::CritCntW-1:0];
    end
  end

  always_comb begin
    if (crit_r == '0) begin
      crit_eff = ppf_pkg::CritCntW'(1);
    end else if (crit_r > ppf_pkg::CritCntW'(ppf_pkg::MaxCriteria)) begin
      crit_eff = ppf_pkg::CritCntW'(ppf_pkg::MaxCriteria);
    end else begin
      crit_eff = crit_r;
    end
  end

  assign in_xfer = in_valid && in_ready;
  assign j_last  = ({1'b0, j_r} + ppf_pkg::RowCntW'(1)) == cnt_r;
  assign i_last  = ({1'b0, i_r} + ppf_pkg::RowCntW'(1)) == cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppf_pkg::ST_LOAD: begin
        if (in_xfer && in_data.last_row) state_nxt = ppf_pkg::ST_CAND_RD;
      end
      ppf_pkg::ST_CAND_RD: state_nxt = ppf_pkg::ST_CAND_LD;
      ppf_pkg::ST_CAND_LD: begin
        state_nxt = rd_data_r.row_excluded ? ppf_pkg::ST_NEXT : ppf_pkg::ST_SWEEP;
      end
      ppf_pkg::ST_SWEEP:   if (j_last) state_nxt = ppf_pkg::ST_DRAIN;
      ppf_pkg::ST_DRAIN:   state_nxt = ppf_pkg::ST_NEXT;
      ppf_pkg::ST_NEXT:    state_nxt = i_last ? ppf_pkg::ST_LOAD : ppf_pkg::ST_CAND_RD;
      default:             state_nxt = ppf_pkg::ST_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    rd_addr  = i_r;
    case (state_r)
      ppf_pkg::ST_LOAD:    in_ready = !out_valid_r;
      ppf_pkg::ST_CAND_RD: rd_addr  = i_r;
      ppf_pkg::ST_SWEEP: begin
        rd_addr = j_r;
        issue   = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && (cnt_r < ppf_pkg::RowCntW'(ppf_pkg::MaxRows))) begin
      mem[cnt_r[ppf_pkg::RowIdxW-1:0]] <= in_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign dom_crit[0] = rd_data_r.criterion_1;
  assign dom_crit[1] = rd_data_r.criterion_2;
  assign dom_crit[2] = rd_data_r.criterion_3;
  assign dom_crit[3] = rd_data_r.criterion_4;
  assign dom_crit[4] = rd_data_r.criterion_5;
  assign dom_crit[5] = rd_data_r.criterion_6;
  assign dom_crit[6] = rd_data_r.criterion_7;
  assign dom_crit[7] = rd_data_r.criterion_8;
  assign cand_crit[0] = cand_r.criterion_1;
  assign cand_crit[1] = cand_r.criterion_2;
  assign cand_crit[2] = cand_r.criterion_3;
  assign cand_crit[3] = cand_r.criterion_4;
  assign cand_crit[4] = cand_r.criterion_5;
  assign cand_crit[5] = cand_r.criterion_6;
  assign cand_crit[6] = cand_r.criterion_7;
  assign cand_crit[7] = cand_r.criterion_8;

  assign ctl.crit_cnt = crit_eff;
  assign ctl.earlier  = pj_r < i_r;

  ppf_merge u_merge (
    .dom_crit  (dom_crit),
    .cand_crit (cand_crit),
    .ctl       (ctl),
    .dominates (dom)
  );

  assign hit = pv_r && (pj_r != i_r) && !rd_data_r.row_excluded &&
               (rd_data_r.partition_id == cand_r.partition_id) && dom;

  always_ff @(posedge clk) begin
    cand_r <= (state_r == ppf_pkg::ST_CAND_LD) ? rd_data_r : cand_r;
    pj_r   <= j_r;
    if (!rst_n) begin
      state_r     <= ppf_pkg::ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pv_r        <= 1'b0;
      kept_r      <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ppf_pkg::ST_LOAD: begin
          i_r    <= '0;
          mask_r <= '0;
          if (in_xfer) begin
            if (cnt_r < ppf_pkg::RowCntW'(ppf_pkg::MaxRows)) begin
              cnt_r <= cnt_r + ppf_pkg::RowCntW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        ppf_pkg::ST_CAND_LD: begin
          kept_r <= !rd_data_r.row_excluded;
          j_r    <= '0;
        end
        ppf_pkg::ST_SWEEP: begin
          if (hit) kept_r <= 1'b0;
          if (!j_last) j_r <= j_r + ppf_pkg::RowIdxW'(1);
        end
        ppf_pkg::ST_DRAIN: begin
          if (hit) kept_r <= 1'b0;
        end
        ppf_pkg::ST_NEXT: begin
          if (i_last) begin
            out_data_r.keep_mask   <= mask_r | (64'(kept_r) << i_r);
            out_data_r.rows_loaded <= cnt_r;
            out_data_r.overflow    <= ovf_r;
            out_valid_r            <= 1'b1;
            cnt_r                  <= '0;
            ovf_r                  <= 1'b0;
          end else begin
            mask_r <= mask_r | (64'(kept_r) << i_r);
            i_r    <= i_r + ppf_pkg::RowIdxW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPF_ASSERT(a_cnt_bound, cnt_r <= ppf_pkg::RowCntW'(ppf_pkg::MaxRows), "row count over capacity")
  `PPF_ASSERT(a_out_gap, out_valid && out_ready |=> !out_valid, "result repeated after transfer")
  `PPF_ASSERT(a_res_cnt, out_valid |-> (out_data.rows_loaded != '0), "empty batch reported")
  `PPF_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule
`default_nettype wire

FILE: src/ppf_lane.sv
// One criterion comparator lane: signed less-or-equal and strictly-less.
// Depends on nothing beyond its ports.
`default_nettype none
module ppf_lane (
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  input  wire logic               active,
  output logic                    le,
  output logic                    lt
);

  // an unused criterion never blocks and never decides
  assign le = active ? (a <= b) : 1'b1;
  assign lt = active ? (a < b)  : 1'b0;

endmodule
`default_nettype wire

FILE: src/ppf_merge.sv
// Criterion lanes plus the merge that decides dominance of one row pair.
// Depends on ppf_pkg and ppf_lane.
`default_nettype none
module ppf_merge (
  input  wire ppf_pkg::crit_vec_t dom_crit,
  input  wire ppf_pkg::crit_vec_t cand_crit,
  input  wire ppf_pkg::cmp_ctl_t  ctl,
  output logic                    dominates
);

  logic [ppf_pkg::MaxCriteria-1:0] le_v;
  logic [ppf_pkg::MaxCriteria-1:0] lt_v;

  for (genvar c = 0; c < ppf_pkg::MaxCriteria; c++) begin : g_lane
    ppf_lane u_lane (
      .a      (dom_crit[c]),
      .b      (cand_crit[c]),
      .active (ppf_pkg::CritCntW'(c) < ctl.crit_cnt),
      .le     (le_v[c]),
      .lt     (lt_v[c])
    );
  end

  // equal on all criteria: the earlier row wins
  assign dominates = (&le_v) && ((|lt_v) || ctl.earlier);

endmodule
`default_nettype wire

FILE: dv/tb_partitioned_pareto_front_filter.sv
// Testbench for partitioned_pareto_front_filter: random and directed row batches,
// checked against an in-bench skyline predictor. Depends on ppf_pkg and the RTL.
`default_nettype none
module tb_partitioned_pareto_front_filter;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ppf_pkg::row_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ppf_pkg::result_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  partitioned_pareto_front_filter uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] part_mem [ppf_pkg::MaxRows];
  logic        excl_mem [ppf_pkg::MaxRows];
  logic signed [31:0] crit_mem [ppf_pkg::MaxRows][ppf_pkg::MaxCriteria];
  int unsigned n_rows = 0;
  bit ovf_seen = 1'b0;
  logic [3:0] crit_sel = ppf_pkg::CritReset;

  ppf_pkg::row_in_t pending_rows[$];
  ppf_pkg::result_t expected_results[$];
  int errors = 0, batches = 0, rows_sent = 0;
  bit recv_hold = 1'b0;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  function automatic bit row_beats(int a, int b, int k);
    bit strict = 1'b0;
    for (int c = 0; c < k; c++) begin
      if (crit_mem[a][c] > crit_mem[b][c]) return 1'b0;
      if (crit_mem[a][c] < crit_mem[b][c]) strict = 1'b1;
    end
    return strict || a < b;
  endfunction

  task automatic add_row(ppf_pkg::row_in_t r);
    pending_rows = {pending_rows, r};
  endtask

  task automatic predict_row(ppf_pkg::row_in_t r);
    ppf_pkg::result_t res;
    int k;
    bit kept;
    if (n_rows < ppf_pkg::MaxRows) begin
      part_mem[n_rows] = r.partition_id;
      excl_mem[n_rows] = r.row_excluded;
      crit_mem[n_rows] = '{r.criterion_1, r.criterion_2, r.criterion_3, r.criterion_4,
                           r.criterion_5, r.criterion_6, r.criterion_7, r.criterion_8};
      n_rows++;
    end else ovf_seen = 1'b1;
    if (!r.last_row) return;
    k = (crit_sel == 0) ? 1 :
        (crit_sel > ppf_pkg::MaxCriteria ? ppf_pkg::MaxCriteria : int'(crit_sel));
    res = '0;
    for (int i = 0; i < n_rows; i++) begin
      kept = !excl_mem[i];
      for (int j = 0; j < n_rows && kept; j++)
        if (j != i && !excl_mem[j] && part_mem[j] == part_mem[i] && row_beats(j, i, k))
          kept = 1'b0;
      res.keep_mask[i] = kept;
    end
    res.rows_loaded = ppf_pkg::RowCntW'(n_rows);
    res.overflow = ovf_seen;
    expected_results = {expected_results, res};
    n_rows = 0;
    ovf_seen = 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_row(in_data);
        rows_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_rows.size() > 0 && (no_idle || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          in_data <= pending_rows.pop_front();
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errors++;
        end else begin
          ppf_pkg::result_t e;
          e = expected_results.pop_front();
          if (e.keep_mask !== out_data.keep_mask)
            $display("%0t: keep_mask exp %h got %h", $realtime, e.keep_mask,
                     out_data.keep_mask);
          if (e.rows_loaded !== out_data.rows_loaded)
            $display("%0t: rows_loaded exp %0d got %0d", $realtime, e.rows_loaded,
                     out_data.rows_loaded);
          if (e.overflow !== out_data.overflow)
            $display("%0t: overflow exp %b got %b", $realtime, e.overflow,
                     out_data.overflow);
          if (e !== out_data) errors++;
          batches++;
        end
      end
      out_ready <= !recv_hold && (no_idle || $urandom_range(99) >= 22);
    end
  end

  // receiver stall: hold off once requested, then release
  initial begin
    wait (hold_req);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
  end

  function automatic logic signed [31:0] rand_crit(bit narrow);
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      default: return narrow ? $signed(32'($urandom_range(6)) - 3) : $signed($urandom);
    endcase
  endfunction

  function automatic ppf_pkg::row_in_t make_row(bit narrow, int parts, bit last);
    ppf_pkg::row_in_t r;
    r.partition_id = (parts == 0) ? 16'($urandom) : 16'($urandom_range(parts - 1));
    if ($urandom_range(15) == 0) r.partition_id = 16'hffff;
    r.row_excluded = ($urandom_range(9) == 0);
    r.criterion_1 = rand_crit(narrow);
    r.criterion_2 = rand_crit(narrow);
    r.criterion_3 = rand_crit(narrow);
    r.criterion_4 = rand_crit(narrow);
    r.criterion_5 = rand_crit(narrow);
    r.criterion_6 = rand_crit(narrow);
    r.criterion_7 = rand_crit(narrow);
    r.criterion_8 = rand_crit(narrow);
    r.last_row = last;
    return r;
  endfunction

  task automatic queue_batch(int len, bit narrow, int parts);
    for (int i = 0; i < len; i++)
      add_row(make_row(narrow, parts, i == len - 1));
  endtask

  task automatic drain_all();
    while (pending_rows.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80 * 70) @(posedge clk);
  endtask

  task automatic cfg_write(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ppf_pkg::RegCritAddr; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    crit_sel = v[3:0];
  endtask

  initial begin
    ppf_pkg::row_in_t r;
    int vals[6];
    vals = '{0, 1, 8, 15, 5, 3};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: single row, ties, extremes, excluded rows, empty-ish batches
    r = '0; r.last_row = 1'b1; add_row(r);
    r = '0; add_row(r); r.last_row = 1'b1; add_row(r);
    r = '0; r.row_excluded = 1'b1; r.last_row = 1'b1; add_row(r);
    r = '1; r.row_excluded = 1'b0; r.last_row = 1'b0; add_row(r);
    r = '0; r.criterion_1 = 32'sh8000_0000; r.criterion_2 = 32'sh7fff_ffff;
    add_row(r);
    r.criterion_1 = 32'sh7fff_ffff; r.criterion_2 = 32'sh8000_0000; r.last_row = 1'b1;
    add_row(r);
    queue_batch(8, 1'b1, 2);
    drain_all();
    // criteria counts: zero, extremes, saturated
    for (int idx = 0; idx < 6; idx++) begin
      cfg_write(vals[idx]);
      for (int b = 0; b < 6; b++) queue_batch($urandom_range(1, 12), 1'b1, 3);
      queue_batch($urandom_range(2, 6), 1'b0, 0);
      drain_all();
    end
    // overflow: 66 rows, the last two dropped, the final one still closing the batch
    cfg_write(2);
    no_idle = 1'b1;
    queue_batch(66, 1'b1, 4);
    drain_all();
    no_idle = 1'b0;
    // back-pressure: receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    queue_batch(4, 1'b1, 2); queue_batch(4, 1'b1, 2); queue_batch(4, 1'b1, 2);
    wait (recv_hold);
    wait (!recv_hold);
    drain_all();
    cfg_write(4);
    for (int b = 0; b < 16; b++) queue_batch($urandom_range(1, 14), 1'b1, 3);
    drain_all();
    r = '1; r.row_excluded = 1'b1; r.last_row = 1'b0;
    add_row(r); r.last_row = 1'b1; add_row(r);
    drain_all();
    $display("covered %0d rows in %0d batches: criteria counts 0 to 15, ties, extremes,",
             rows_sent, batches);
    $display("excluded rows, a full batch with dropped rows and a long receiver stall");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/ppf_pkg.sv
src/ppf_lane.sv
src/ppf_merge.sv
src/partitioned_pareto_front_filter.sv
dv/tb_partitioned_pareto_front_filter.sv
